// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro places one labeled concurrent assertion, reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// ante implies cons in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// ante implies cons in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/tpf_pkg.sv =====
// Types, codes and header byte function for the telemetry packet framer.
// No dependencies.
`timescale 1ns / 1ps

package tpf_pkg;

	localparam logic [15:0] MAX_LEN    = 16'd65526;
	localparam logic [15:0] LEN_BIAS   = 16'd9;
	localparam logic [4:0]  WORD0_BASE = 5'b00001;
	localparam logic [1:0]  W1_FLAGS   = 2'b11;
	localparam logic [3:0]  HDR_LAST   = 4'd15;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_BYTE   = 2'd1,
		OP_SETSEQ = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CMD_HDR  = 2'd0,
		CMD_BYTE = 2'd1,
		CMD_REJ  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t    kind;
		logic [7:0]   data;
		logic         last;
		logic [10:0]  apid;
		logic [13:0]  seq;
		logic [15:0]  dlen;
		logic [31:0]  tc;
		logic [23:0]  tf;
	} cmd_t;

	function automatic logic [7:0] hdr_byte(input cmd_t c, input logic [3:0] idx);
		logic [15:0] w0;
		logic [15:0] w1;
		logic [7:0]  b;
		w0 = {WORD0_BASE, c.apid};
		w1 = {W1_FLAGS, c.seq};
		case (idx)
			4'd0:    b = w0[15:8];
			4'd1:    b = w0[7:0];
			4'd2:    b = w1[15:8];
			4'd3:    b = w1[7:0];
			4'd4:    b = c.dlen[15:8];
			4'd5:    b = c.dlen[7:0];
			4'd6:    b = c.tc[31:24];
			4'd7:    b = c.tc[23:16];
			4'd8:    b = c.tc[15:8];
			4'd9:    b = c.tc[7:0];
			4'd10:   b = c.tf[23:16];
			4'd11:   b = c.tf[15:8];
			4'd12:   b = c.tf[7:0];
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

// ===== hdl/tpf_front.sv =====
// Front end: accepts input transactions, tracks sequence count and packet
// state, and issues commands to the queue. Depends on tpf_pkg.
`timescale 1ns / 1ps

module tpf_front import tpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [1:0]  operation,
	input  logic [15:0] payload_length,
	input  logic [31:0] time_coarse,
	input  logic [23:0] time_fine,
	input  logic [7:0]  data_byte,
	input  logic [13:0] seq_value,
	input  logic [10:0] apid,
	output logic        cmd_wr,
	output cmd_t        cmd
);

	logic [13:0] seq_q;
	logic [15:0] remaining_q;
	logic        discarding_q;

	logic [13:0] seq_d;
	logic [15:0] remaining_d;
	logic        discarding_d;

	always_comb begin
		seq_d        = seq_q;
		remaining_d  = remaining_q;
		discarding_d = discarding_q;
		cmd_wr       = 1'b0;
		cmd.kind     = CMD_BYTE;
		cmd.data     = data_byte;
		cmd.last     = 1'b0;
		cmd.apid     = apid;
		cmd.seq      = seq_q;
		cmd.dlen     = payload_length + LEN_BIAS;
		cmd.tc       = time_coarse;
		cmd.tf       = time_fine;
		unique case (operation)
			OP_START: begin
				remaining_d = payload_length;
				cmd_wr      = 1'b1;
				if (payload_length > MAX_LEN) begin
					discarding_d = 1'b1;
					cmd.kind     = CMD_REJ;
					cmd.data     = 8'd0;
					cmd.last     = 1'b1;
				end else begin
					discarding_d = 1'b0;
					seq_d        = seq_q + 14'd1;
					cmd.kind     = CMD_HDR;
					cmd.last     = (payload_length == 16'd0);
				end
			end
			OP_BYTE: begin
				if (remaining_q != 16'd0) begin
					remaining_d = remaining_q - 16'd1;
					if (discarding_q) begin
						if (remaining_q == 16'd1)
							discarding_d = 1'b0;
					end else begin
						cmd_wr   = 1'b1;
						cmd.last = (remaining_q == 16'd1);
					end
				end
			end
			OP_SETSEQ: begin
				seq_d = seq_value;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= '0;
			remaining_q  <= '0;
			discarding_q <= 1'b0;
		end else if (accept) begin
			seq_q        <= seq_d;
			remaining_q  <= remaining_d;
			discarding_q <= discarding_d;
		end
	end

endmodule

// ===== hdl/tpf_cmd_fifo.sv =====
// Short command queue between front and back ends, register based.
// Depends on tpf_pkg.
`timescale 1ns / 1ps

module tpf_cmd_fifo import tpf_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic rd,
	output cmd_t rd_cmd,
	output logic not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hdl/tpf_back.sv =====
// Back end: expands commands into packet bytes and holds the result register.
// Depends on tpf_pkg.
`timescale 1ns / 1ps

module tpf_back import tpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_avail,
	input  cmd_t       cmd,
	output logic       cmd_rd,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] packet_byte,
	output logic       last_of_packet,
	output logic       rejected
);

	logic [3:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_rej_q;

	logic       load;
	logic [7:0] nxt_byte;
	logic       nxt_last;

	assign load   = cmd_avail && (!out_valid_q || pop);
	assign cmd_rd = load && ((cmd.kind != CMD_HDR) || (idx_q == HDR_LAST));

	always_comb begin
		if (cmd.kind == CMD_HDR) begin
			nxt_byte = hdr_byte(cmd, idx_q);
			nxt_last = cmd.last && (idx_q == HDR_LAST);
		end else begin
			nxt_byte = cmd.data;
			nxt_last = cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (load && cmd.kind == CMD_HDR)
				idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= nxt_byte;
			out_last_q <= nxt_last;
			out_rej_q  <= (cmd.kind == CMD_REJ);
		end
	end

	assign empty          = !out_valid_q;
	assign packet_byte    = out_byte_q;
	assign last_of_packet = out_last_q;
	assign rejected       = out_rej_q;

endmodule

// ===== hdl/telemetry_packet_framer.sv =====
// Telemetry packet framer top level: front end, command queue, back end.
// Depends on tpf_pkg, tpf_front, tpf_cmd_fifo, tpf_back.
//
//   channel   handshake           payload
//   input     push / full         operation, payload_length, time_coarse,
//                                 time_fine, data_byte, seq_value
//   result    empty / pop         packet_byte, last_of_packet, rejected
//   config    cfg_valid/cfg_ready cfg_data (apid)
//
// One input transaction per cycle enters the front end while the queue has room.
// The back end sends one byte per cycle unless stalled by the result side:
// 16 for a start, 1 for a payload byte or a reject, so an accepted packet is 16 + length bytes.
// Reset clears counters, queue and the result valid flag (not the result data); apid resets to 0.
// A stalled result side fills the CMD_DEPTH-entry queue, then raises full.
`timescale 1ns / 1ps

module telemetry_packet_framer import tpf_pkg::*; #(
	parameter int CMD_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  operation,
	input  logic [15:0] payload_length,
	input  logic [31:0] time_coarse,
	input  logic [23:0] time_fine,
	input  logic [7:0]  data_byte,
	input  logic [13:0] seq_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  packet_byte,
	output logic        last_of_packet,
	output logic        rejected
);

	logic [10:0] apid_q;
	logic        accept;
	logic        cmd_wr;
	cmd_t        cmd_in;
	cmd_t        cmd_head;
	logic        cmd_avail;
	logic        cmd_rd;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			apid_q <= '0;
		else if (cfg_valid && cfg_ready)
			apid_q <= cfg_data;
	end

	tpf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.operation      (operation),
		.payload_length (payload_length),
		.time_coarse    (time_coarse),
		.time_fine      (time_fine),
		.data_byte      (data_byte),
		.seq_value      (seq_value),
		.apid           (apid_q),
		.cmd_wr         (cmd_wr),
		.cmd            (cmd_in)
	);

	tpf_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (cmd_wr && accept),
		.wr_cmd    (cmd_in),
		.full      (full),
		.rd        (cmd_rd),
		.rd_cmd    (cmd_head),
		.not_empty (cmd_avail)
	);

	tpf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_avail      (cmd_avail),
		.cmd            (cmd_head),
		.cmd_rd         (cmd_rd),
		.empty          (empty),
		.pop            (pop),
		.packet_byte    (packet_byte),
		.last_of_packet (last_of_packet),
		.rejected       (rejected)
	);

endmodule

// ===== hdl/tpf_checker.sv =====
// Port-level checker for the telemetry packet framer, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] packet_byte,
	input logic       last_of_packet,
	input logic       rejected
);

	`ASSERT_IMP(a_rej_is_last, clk, arst_n, !empty && rejected, last_of_packet)
	`ASSERT_IMP(a_rej_byte_zero, clk, arst_n, !empty && rejected, packet_byte == 8'd0)
	`ASSERT_NEXT(a_stall_keeps, clk, arst_n, !empty && !pop, !empty)
	`ASSERT_NEXT(a_stall_stable, clk, arst_n, !empty && !pop, $stable(packet_byte) && $stable(last_of_packet) && $stable(rejected))

endmodule

bind telemetry_packet_framer tpf_checker u_tpf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.packet_byte    (packet_byte),
	.last_of_packet (last_of_packet),
	.rejected       (rejected)
);
